>>> rtl/ects_pkg.sv
`timescale 1ns / 1ps

package ects_pkg;

  localparam int unsigned CoreIdW = 12;
  localparam int unsigned PageW = 20;
  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned StatusW = 2;

  localparam logic [3:0] KIND_COMPONENT = 4'h1;
  localparam logic [3:0] KIND_ADDRESS = 4'h5;
  localparam logic [3:0] KIND_END = 4'hF;

  localparam logic [CoreIdW-1:0] CID_ARMCR4 = 12'h83E;
  localparam logic [CoreIdW-1:0] CID_ARMCM3 = 12'h82A;
  localparam logic [CoreIdW-1:0] CID_ARM7 = 12'h825;
  localparam logic [CoreIdW-1:0] CID_CHIPCOMMON = 12'h800;
  localparam logic [CoreIdW-1:0] CID_SOCRAM = 12'h80E;
  localparam logic [CoreIdW-1:0] CID_SDIODEV = 12'h829;
  localparam logic [CoreIdW-1:0] CID_D11 = 12'h812;

  localparam logic [StatusW-1:0] PHASE_RUNNING = 2'd0;
  localparam logic [StatusW-1:0] PHASE_END = 2'd1;
  localparam logic [StatusW-1:0] PHASE_LIMIT = 2'd2;

  localparam logic ACTION_START = 1'b0;

  typedef struct packed {
    logic [CoreIdW-1:0] current_core;
    logic               pair_pending;
    logic [CoreIdW-1:0] pending_core;
    logic [PageW-1:0]   chipcommon_page;
    logic [CoreIdW-1:0] arm_kind_seen;
    logic [PageW-1:0]   arm_wrapper_page;
    logic [PageW-1:0]   arm_regs_page;
    logic [PageW-1:0]   d11_wrapper_page;
    logic [PageW-1:0]   socram_wrapper_page;
    logic [PageW-1:0]   socram_regs_page;
    logic [PageW-1:0]   sdio_regs_page;
    logic [CountW-1:0]  words_seen;
    logic [StatusW-1:0] scan_phase;
  } scan_state_t;

endpackage

>>> rtl/ects_step.sv
`timescale 1ns / 1ps

module ects_step import ects_pkg::*; #(
  parameter int unsigned MAX_WORDS = 128
) (
  input  scan_state_t        state_i,
  input  logic               action_i,
  input  logic [WordW-1:0]   erom_word_i,
  output scan_state_t        state_o
);

  localparam logic [CountW-1:0] MaxWordsC = CountW'(MAX_WORDS);

  logic [3:0]       kind;
  logic             wrap;
  logic [PageW-1:0] page;
  logic             consumed;

  assign kind = erom_word_i[3:0];
  assign wrap = |erom_word_i[7:6];
  assign page = erom_word_i[WordW-1:12];

  always_comb begin
    state_o = state_i;
    consumed = 1'b0;
    if (action_i == ACTION_START) begin
      state_o = '0;
    end else if (state_i.scan_phase == PHASE_RUNNING) begin
      if (state_i.pair_pending) begin
        state_o.pair_pending = 1'b0;
        if (kind == KIND_COMPONENT) begin
          state_o.current_core = state_i.pending_core;
          consumed = 1'b1;
        end
      end
      if (!consumed) begin
        case (kind)
          KIND_END: begin
            state_o.scan_phase = PHASE_END;
          end
          KIND_COMPONENT: begin
            state_o.pair_pending = 1'b1;
            state_o.pending_core = erom_word_i[19:8];
          end
          KIND_ADDRESS: begin
            case (state_i.current_core)
              CID_CHIPCOMMON: begin
                if (!wrap) state_o.chipcommon_page = page;
              end
              CID_ARMCM3, CID_ARM7, CID_ARMCR4: begin
                state_o.arm_kind_seen = state_i.current_core;
                if (wrap) begin
                  if (state_i.arm_wrapper_page == '0) state_o.arm_wrapper_page = page;
                end else begin
                  if (state_i.arm_regs_page == '0) state_o.arm_regs_page = page;
                end
              end
              CID_SOCRAM: begin
                if (wrap) begin
                  state_o.socram_wrapper_page = page;
                end else if (state_i.socram_regs_page == '0) begin
                  state_o.socram_regs_page = page;
                end
              end
              CID_SDIODEV: begin
                if (!wrap) state_o.sdio_regs_page = page;
              end
              CID_D11: begin
                if (wrap) state_o.d11_wrapper_page = page;
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
      state_o.words_seen = state_i.words_seen + CountW'(1);
      if (state_o.scan_phase == PHASE_RUNNING && state_o.words_seen >= MaxWordsC) begin
        state_o.scan_phase = PHASE_LIMIT;
        state_o.pair_pending = 1'b0;
      end
    end
  end

endmodule

>>> rtl/erom_core_table_scan.sv
`timescale 1ns / 1ps

// Scans enumeration ROM descriptor words and keeps a table of base addresses for the
// chipcommon, ARM, SoC RAM, SDIO device and D11 cores. Every request, a start or one
// descriptor word, gives one result that shows the table and scan status after it.
// The decode and table update are combinational logic in front of the table registers,
// which also hold the result, so a new request is accepted in every cycle in which
// the previous result is taken or none is waiting. Results are registered and appear
// in the cycle after their request is accepted.
module erom_core_table_scan import ects_pkg::*; #(
  parameter int unsigned MAX_WORDS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [WordW-1:0]   erom_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WordW-1:0]   chipcommon_base_o,
  output logic [CoreIdW-1:0] arm_core_kind_o,
  output logic [WordW-1:0]   arm_wrapper_base_o,
  output logic [WordW-1:0]   arm_regs_base_o,
  output logic [WordW-1:0]   d11_wrapper_base_o,
  output logic [WordW-1:0]   socram_wrapper_base_o,
  output logic [WordW-1:0]   socram_regs_base_o,
  output logic [WordW-1:0]   sdio_regs_base_o,
  output logic [StatusW-1:0] scan_status_o
);

  scan_state_t state_q, state_d, step_state;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;

  ects_step #(
    .MAX_WORDS (MAX_WORDS)
  ) u_step (
    .state_i     (state_q),
    .action_i    (action_i),
    .erom_word_i (erom_word_i),
    .state_o     (step_state)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = in_accept ? step_state : state_q;
    out_valid_d = in_accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The table only changes on an accepted request, which needs the result slot free,
  // so the table registers double as the result register.
  assign out_valid_o = out_valid_q;
  assign chipcommon_base_o = {state_q.chipcommon_page, 12'h000};
  assign arm_core_kind_o = state_q.arm_kind_seen;
  assign arm_wrapper_base_o = {state_q.arm_wrapper_page, 12'h000};
  assign arm_regs_base_o = {state_q.arm_regs_page, 12'h000};
  assign d11_wrapper_base_o = {state_q.d11_wrapper_page, 12'h000};
  assign socram_wrapper_base_o = {state_q.socram_wrapper_page, 12'h000};
  assign socram_regs_base_o = {state_q.socram_regs_page, 12'h000};
  assign sdio_regs_base_o = {state_q.sdio_regs_page, 12'h000};
  assign scan_status_o = state_q.scan_phase;

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && action_i == ACTION_START |=>
      scan_status_o == PHASE_RUNNING && chipcommon_base_o == '0 && arm_core_kind_o == '0)
    else $error("start request did not clear the table");

  a_ended_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.scan_phase != PHASE_RUNNING && !(in_accept && action_i == ACTION_START) |=>
      $stable(state_q))
    else $error("table changed after the scan ended");

  a_arm_wrapper_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arm_wrapper_base_o != '0 && !(in_accept && action_i == ACTION_START) |=>
      $stable(arm_wrapper_base_o))
    else $error("ARM wrapper base overwritten");

  a_no_pending_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.scan_phase != PHASE_RUNNING |-> !state_q.pair_pending)
    else $error("component pairing pending after scan end");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(state_q) && out_valid_o)
    else $error("result changed while waiting to be taken");

endmodule
